>>> src/lfh_pkg.sv
package lfh_pkg;

	// Occupancy words: one bit per slot, set while the slot holds a nonzero value.
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	// Command codes.
	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_SET = 2'd1;
	localparam logic [1:0] CMD_TAS = 2'd2;

	// Status codes.
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_ERR   = 2'd1;
	localparam logic [1:0] STS_INUSE = 2'd2;

	// Command transfer.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] slot_index;
		logic [31:0] slot_value;
	} req_t;

	// Result transfer.
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] assigned_index;
		logic [8:0] free_slots;
		logic [8:0] first_free;
	} rsp_t;

	// Outcome of a search for the lowest free bit in one occupancy word.
	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} find_t;

endpackage

>>> src/lowest_free_handle_table.sv
// Handle table with lowest-free-slot allocation. A command is taken when start is high
// and busy is low; its single result appears on rsp for exactly one cycle with done high
// and cannot be held off. Stored values are never returned, so the table keeps one
// occupancy bit per slot in a synchronous memory of 32-bit words. After reset the block
// is busy while it clears that memory word by word. An error, a full table, an unknown
// command or an add with a zero value is answered without reading the memory. Any
// other command reads its word and, where the slot's occupancy bit changes, writes
// it back modified. When the lowest free slot was just taken, the search for the next
// one continues upward one word per cycle until a free slot or the end of the table is
// reached (at most 7 further words at the default capacity). The next command may
// start in the cycle its predecessor's result is shown.
module lowest_free_handle_table #(
	parameter int CAPACITY = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lfh_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output lfh_pkg::rsp_t rsp
);

	localparam int NWORDS    = (CAPACITY + lfh_pkg::WORD_W - 1) / lfh_pkg::WORD_W;
	localparam int WADDR_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int XW        = WADDR_W + lfh_pkg::BIT_W;
	localparam int LF_W      = $clog2(CAPACITY + 1);
	localparam int CMP_W     = XW + LF_W;
	localparam int LAST_BITS = CAPACITY - (NWORDS - 1) * lfh_pkg::WORD_W;
	localparam logic [lfh_pkg::WORD_W-1:0] ALL_ONES  = {lfh_pkg::WORD_W{1'b1}};
	localparam logic [lfh_pkg::WORD_W-1:0] LAST_MASK = ALL_ONES >> (lfh_pkg::WORD_W - LAST_BITS);
	localparam logic [WADDR_W-1:0] LAST_ADDR = WADDR_W'(NWORDS - 1);
	localparam logic [LF_W-1:0]    CAP_LF    = LF_W'(CAPACITY);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_RMW   = 4'b0100,
		ST_SCAN  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Occupancy memory and its registered read port.
	logic [lfh_pkg::WORD_W-1:0] occ_mem [NWORDS];
	logic [lfh_pkg::WORD_W-1:0] occ_rd_q;
	logic                       rd_en;
	logic [WADDR_W-1:0]         rd_addr;
	logic                       wr_en;
	logic [WADDR_W-1:0]         wr_addr;
	logic [lfh_pkg::WORD_W-1:0] wr_data;

	// Control state.
	logic [WADDR_W-1:0] clr_addr_q;
	logic [LF_W-1:0]    lf_q, lf_d;
	logic [LF_W-1:0]    fc_q, fc_d;
	logic               done_q, done_d;

	// Command being worked on.
	logic [1:0]         cmd_q;
	logic [XW-1:0]      x_q;
	logic               val_nz_q;
	logic [WADDR_W-1:0] scan_addr_q, scan_addr_d;
	lfh_pkg::rsp_t      rsp_q, rsp_d;

	// Helpers.
	logic [XW-1:0]                lf_x;
	logic [WADDR_W-1:0]           x_word;
	logic [lfh_pkg::BIT_W-1:0]    x_bit;
	logic [lfh_pkg::WORD_W-1:0]   bit_oh;
	logic [lfh_pkg::WORD_W-1:0]   above;
	logic                         bit_used;
	logic                         x_lt_lf;
	logic                         x_eq_lf;
	logic                         idx_ok;
	logic                         lf_ok;
	logic                         val_nz_in;
	logic [WADDR_W-1:0]           srch_addr;
	logic [lfh_pkg::WORD_W-1:0]   fz_occ;
	logic [lfh_pkg::WORD_W-1:0]   fz_allow;
	lfh_pkg::find_t               fz_hit;
	logic                         fin;
	logic [1:0]                   sts;
	logic [7:0]                   rep;

	assign lf_x      = XW'(lf_q);
	assign x_word    = x_q[XW-1:lfh_pkg::BIT_W];
	assign x_bit     = x_q[lfh_pkg::BIT_W-1:0];
	assign bit_oh    = lfh_pkg::WORD_W'(1) << x_bit;
	assign above     = (ALL_ONES << x_bit) << 1;
	assign bit_used  = occ_rd_q[x_bit];
	assign x_lt_lf   = CMP_W'(x_q) < CMP_W'(lf_q);
	assign x_eq_lf   = CMP_W'(x_q) == CMP_W'(lf_q);
	assign idx_ok    = 32'(req.slot_index) < CAPACITY;
	assign lf_ok     = (fc_q != '0) && (lf_q < CAP_LF);
	assign val_nz_in = req.slot_value != '0;

	// The search looks above the target bit in the word just modified, or at a whole word
	// while the scan runs; bits past the end of the table never count as free.
	always_comb begin
		if (state_q == ST_RMW) begin
			srch_addr = x_word;
			fz_occ    = occ_rd_q | bit_oh;
			fz_allow  = above;
		end else begin
			srch_addr = scan_addr_q;
			fz_occ    = occ_rd_q;
			fz_allow  = ALL_ONES;
		end
		if (srch_addr == LAST_ADDR) begin
			fz_allow = fz_allow & LAST_MASK;
		end
	end

	lfh_first_zero u_find (
		.occ   (fz_occ),
		.allow (fz_allow),
		.hit   (fz_hit)
	);

	// Command sequencing.
	always_comb begin
		state_d     = state_q;
		rd_en       = 1'b0;
		rd_addr     = lf_x[XW-1:lfh_pkg::BIT_W];
		wr_en       = 1'b0;
		wr_addr     = x_word;
		wr_data     = occ_rd_q;
		lf_d        = lf_q;
		fc_d        = fc_q;
		scan_addr_d = scan_addr_q;
		fin         = 1'b0;
		sts         = lfh_pkg::STS_OK;
		rep         = 8'(x_q);

		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = '0;
				if (clr_addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					rep = req.slot_index[7:0];
					case (req.cmd)
						lfh_pkg::CMD_ADD: begin
							if (!lf_ok) begin
								fin = 1'b1;
								sts = lfh_pkg::STS_ERR;
								rep = '0;
							end else if (!val_nz_in) begin
								fin = 1'b1;
								rep = 8'(lf_q);
							end else begin
								rd_en   = 1'b1;
								state_d = ST_RMW;
							end
						end
						lfh_pkg::CMD_SET, lfh_pkg::CMD_TAS: begin
							if (!idx_ok) begin
								fin = 1'b1;
								sts = lfh_pkg::STS_ERR;
							end else begin
								rd_en   = 1'b1;
								rd_addr = req.slot_index[XW-1:lfh_pkg::BIT_W];
								state_d = ST_RMW;
							end
						end
						default: begin
							fin = 1'b1;
							sts = lfh_pkg::STS_ERR;
						end
					endcase
				end
			end
			ST_RMW: begin
				if (bit_used) begin
					fin = 1'b1;
					if (cmd_q == lfh_pkg::CMD_TAS) begin
						sts = lfh_pkg::STS_INUSE;
					end else if (!val_nz_q) begin
						// Freeing a used slot.
						wr_en   = 1'b1;
						wr_data = occ_rd_q & ~bit_oh;
						fc_d    = fc_q + 1'b1;
						if (x_lt_lf) begin
							lf_d = LF_W'(x_q);
						end
					end
				end else if (!val_nz_q) begin
					// Zero written to a free slot leaves it free.
					fin = 1'b1;
					if (x_lt_lf) begin
						lf_d = LF_W'(x_q);
					end
				end else begin
					// Taking a free slot.
					wr_en   = 1'b1;
					wr_data = occ_rd_q | bit_oh;
					if (fc_q != '0) begin
						fc_d = fc_q - 1'b1;
					end
					if (!x_eq_lf) begin
						fin = 1'b1;
					end else if (fz_hit.found) begin
						fin  = 1'b1;
						lf_d = LF_W'({x_word, fz_hit.pos});
					end else if (x_word == LAST_ADDR) begin
						fin  = 1'b1;
						lf_d = CAP_LF;
					end else begin
						rd_en       = 1'b1;
						rd_addr     = WADDR_W'(x_word + 1'b1);
						scan_addr_d = WADDR_W'(x_word + 1'b1);
						state_d     = ST_SCAN;
					end
				end
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (fz_hit.found) begin
					fin  = 1'b1;
					lf_d = LF_W'({scan_addr_q, fz_hit.pos});
				end else if (scan_addr_q == LAST_ADDR) begin
					fin  = 1'b1;
					lf_d = CAP_LF;
				end else begin
					rd_en       = 1'b1;
					rd_addr     = WADDR_W'(scan_addr_q + 1'b1);
					scan_addr_d = WADDR_W'(scan_addr_q + 1'b1);
				end
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		done_d = fin;
		rsp_d  = '{
			status:         sts,
			assigned_index: rep,
			free_slots:     9'(fc_d),
			first_free:     9'(lf_d)
		};
	end

	// Occupancy memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			occ_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			occ_rd_q <= occ_mem[rd_addr];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			lf_q       <= '0;
			fc_q       <= CAP_LF;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			lf_q    <= lf_d;
			fc_q    <= fc_d;
			done_q  <= done_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= WADDR_W'(clr_addr_q + 1'b1);
			end
		end
	end

	// Command and result registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q    <= req.cmd;
			val_nz_q <= val_nz_in;
			x_q      <= (req.cmd == lfh_pkg::CMD_ADD) ? lf_x : XW'(req.slot_index);
		end
		scan_addr_q <= scan_addr_d;
		if (fin) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	// A result only appears once the block is ready for the next command.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while the block is busy");

	// The free count never exceeds the table size.
	a_fc_range: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= CAP_LF)
		else $error("free count above capacity");

	// The lowest free index stays within the table or marks it full.
	a_lf_range: assert property (@(posedge clk) disable iff (!arst_n)
		lf_q <= CAP_LF)
		else $error("lowest free index beyond capacity");

	// Between commands, an empty free count and a full-table index go together.
	a_full_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((fc_q == '0) == (lf_q == CAP_LF)))
		else $error("free count and lowest free index disagree");

	// Every modify cycle works on a word fetched in the cycle before.
	a_rmw_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RMW) |-> $past(rd_en))
		else $error("modify without a preceding read");
`endif

endmodule

>>> src/lfh_first_zero.sv
module lfh_first_zero (
	input  logic [lfh_pkg::WORD_W-1:0] occ,
	input  logic [lfh_pkg::WORD_W-1:0] allow,
	output lfh_pkg::find_t             hit
);

	logic [lfh_pkg::WORD_W-1:0] cand;

	// A bit is a candidate when its slot is free and the caller allows that position.
	assign cand = ~occ & allow;

	// Priority encoder: the lowest candidate wins.
	always_comb begin
		hit.found = |cand;
		hit.pos   = '0;
		for (int i = lfh_pkg::WORD_W - 1; i >= 0; i--) begin
			if (cand[i]) begin
				hit.pos = lfh_pkg::BIT_W'(i);
			end
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

	import lfh_pkg::*;

	localparam int CAP = 256;
	localparam int RANDOM_CMDS = 1170;
	localparam int SETTLE_CYCLES = 16;

	// Command code that the block must reject.
	localparam logic [1:0] CMD_BAD = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	lowest_free_handle_table #(
		.CAPACITY(CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the handle table.
	logic [31:0] shadow_slots [CAP];
	int unsigned shadow_free;
	int unsigned shadow_lowest;

	// Results owed by the block, oldest first.
	rsp_t pending_results [$];
	int mismatch_count = 0;

	// Expectation typed into a directed row travels next to the command.
	logic drv_typed;
	rsp_t drv_want;

	// Idle pacing on the command side.
	bit quiet_run = 1'b0;

	// Directed rows.
	typedef struct {
		req_t r;
		bit fill_first;
		bit typed;
		rsp_t want;
	} dir_row_t;

	dir_row_t dir_rows [$];

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("tb: mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
		end
	endtask

	function automatic int unsigned next_free_from(input int unsigned from);
		int unsigned i;
		for (i = from; i < CAP; i++) begin
			if (shadow_slots[i] == 32'd0) begin
				return i;
			end
		end
		return CAP;
	endfunction

	task automatic clear_shadow();
		for (int i = 0; i < CAP; i++) begin
			shadow_slots[i] = 32'd0;
		end
		shadow_free = CAP;
		shadow_lowest = 0;
	endtask

	// Apply one command to the shadow table and work out the block's answer.
	task automatic predict_handle_cmd(input req_t r, output rsp_t res);
		int unsigned idx;
		int unsigned report;
		logic [31:0] val;
		logic [1:0] status;
		idx = 32'(r.slot_index);
		val = r.slot_value;
		status = STS_OK;
		report = idx;
		case (r.cmd)
			CMD_ADD: begin
				if (shadow_free == 0 || shadow_lowest >= CAP) begin
					status = STS_ERR;
					report = 0;
				end else begin
					report = shadow_lowest;
					// A zero value reports the slot but leaves it free.
					if (val != 32'd0) begin
						shadow_slots[report] = val;
						shadow_free--;
						shadow_lowest = next_free_from(report + 1);
					end
				end
			end
			CMD_SET, CMD_TAS: begin
				if (idx >= CAP) begin
					status = STS_ERR;
				end else if (shadow_slots[idx] != 32'd0) begin
					if (r.cmd == CMD_TAS) begin
						status = STS_INUSE;
					end else begin
						shadow_slots[idx] = val;
						if (val == 32'd0) begin
							shadow_free++;
							if (idx < shadow_lowest) begin
								shadow_lowest = idx;
							end
						end else if (idx == shadow_lowest) begin
							shadow_lowest = next_free_from(idx);
						end
					end
				end else begin
					// Target slot is free; a zero value keeps it free.
					if (val == 32'd0) begin
						if (idx < shadow_lowest) begin
							shadow_lowest = idx;
						end
					end else begin
						shadow_slots[idx] = val;
						if (shadow_free > 0) begin
							shadow_free--;
						end
						if (idx == shadow_lowest) begin
							shadow_lowest = next_free_from(idx);
						end
					end
				end
			end
			default: begin
				status = STS_ERR;
			end
		endcase
		res.status = status;
		res.assigned_index = report[7:0];
		res.free_slots = shadow_free[8:0];
		res.first_free = shadow_lowest[8:0];
	endtask

	// Record accepted commands and check every result against the oldest expectation.
	always @(posedge clk) begin : watch
		rsp_t want;
		if (arst_n) begin
			if (start && !busy) begin
				predict_handle_cmd(req, want);
				if (drv_typed) begin
					want = drv_want;
				end
				pending_results.push_back(want);
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("result with no command outstanding");
				end else begin
					want = pending_results.pop_front();
					check_field("status", 32'(rsp.status), 32'(want.status));
					check_field("assigned_index", 32'(rsp.assigned_index),
						32'(want.assigned_index));
					check_field("free_slots", 32'(rsp.free_slots), 32'(want.free_slots));
					check_field("first_free", 32'(rsp.first_free), 32'(want.first_free));
				end
			end
		end
	end

	// Mostly short gaps, now and then a long one, none at all during a quiet run.
	function automatic int pick_gap();
		int r;
		if (quiet_run) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Present one command at the falling edge and hold it until the transfer.
	task automatic send_cmd(input req_t r, input bit typed, input rsp_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		req = r;
		drv_typed = typed;
		drv_want = want;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic add_row(input logic [1:0] cmd, input logic [15:0] idx,
			input logic [31:0] val, input bit fill, input bit typed,
			input logic [1:0] st, input logic [7:0] ai, input logic [8:0] fs,
			input logic [8:0] ff);
		dir_row_t row;
		row.r = '{cmd: cmd, slot_index: idx, slot_value: val};
		row.fill_first = fill;
		row.typed = typed;
		row.want = '{status: st, assigned_index: ai, free_slots: fs, first_free: ff};
		dir_rows.push_back(row);
	endtask

	function automatic logic [31:0] any_nonzero();
		logic [31:0] v;
		v = $urandom;
		if (v == 32'd0) begin
			v = 32'd1;
		end
		return v;
	endfunction

	// Random command; a draining phase favors zero writes that free slots.
	function automatic req_t rand_cmd(input bit draining);
		req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			r.cmd = CMD_BAD;
		end else if (pick < (draining ? 25 : 55)) begin
			r.cmd = CMD_ADD;
		end else if (pick < 82) begin
			r.cmd = CMD_SET;
		end else begin
			r.cmd = CMD_TAS;
		end
		pick = $urandom_range(0, 99);
		if (pick < 7) begin
			r.slot_index = 16'($urandom_range(0, 65535));
		end else if (pick < 20) begin
			r.slot_index = 16'($urandom_range(0, 15));
		end else begin
			r.slot_index = 16'($urandom_range(0, CAP - 1));
		end
		pick = $urandom_range(0, 99);
		if (pick < (draining ? 60 : 15)) begin
			r.slot_value = 32'd0;
		end else if (pick < (draining ? 65 : 25)) begin
			r.slot_value = 32'hFFFF_FFFF;
		end else begin
			r.slot_value = any_nonzero();
		end
		return r;
	endfunction

	// Main sequence: reset, directed rows, then random phases.
	initial begin : stimulus
		req_t r;
		rsp_t none;
		int sent;
		bit draining;
		int phase_len;
		none = '0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		drv_typed = 1'b0;
		drv_want = '0;
		clear_shadow();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows: empty table, extremes, errors and the zero-value cases.
		add_row(CMD_ADD, 16'd0, 32'd1, 0, 1, STS_OK, 8'd0, 9'd255, 9'd1);
		add_row(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 0, 1, STS_OK, 8'd1, 9'd254, 9'd2);
		add_row(CMD_ADD, 16'd0, 32'd0, 0, 1, STS_OK, 8'd2, 9'd254, 9'd2);
		add_row(CMD_SET, 16'd0, 32'd0, 0, 1, STS_OK, 8'd0, 9'd255, 9'd0);
		add_row(CMD_TAS, 16'd1, 32'd5, 0, 1, STS_INUSE, 8'd1, 9'd255, 9'd0);
		add_row(CMD_TAS, 16'd0, 32'd0, 0, 1, STS_OK, 8'd0, 9'd255, 9'd0);
		add_row(CMD_TAS, 16'd0, 32'd7, 0, 1, STS_OK, 8'd0, 9'd254, 9'd2);
		add_row(CMD_SET, 16'd255, 32'd9, 0, 1, STS_OK, 8'd255, 9'd253, 9'd2);
		add_row(CMD_SET, 16'd256, 32'd1, 0, 1, STS_ERR, 8'd0, 9'd253, 9'd2);
		add_row(CMD_SET, 16'hFFFF, 32'd1, 0, 1, STS_ERR, 8'hFF, 9'd253, 9'd2);
		add_row(CMD_TAS, 16'hFFFF, 32'd0, 0, 1, STS_ERR, 8'hFF, 9'd253, 9'd2);
		add_row(CMD_BAD, 16'h1234, 32'h55, 0, 1, STS_ERR, 8'h34, 9'd253, 9'd2);
		add_row(CMD_SET, 16'd1, 32'h8000_0000, 0, 0, STS_OK, 8'd0, 9'd0, 9'd0);
		add_row(CMD_SET, 16'd1, 32'd0, 0, 1, STS_OK, 8'd1, 9'd254, 9'd1);
		add_row(CMD_SET, 16'd255, 32'd0, 0, 1, STS_OK, 8'd255, 9'd255, 9'd1);
		// The table is filled by adds before this row, so every slot is taken.
		add_row(CMD_ADD, 16'd0, 32'd5, 1, 1, STS_ERR, 8'd0, 9'd0, 9'd256);
		add_row(CMD_ADD, 16'd0, 32'd0, 0, 1, STS_ERR, 8'd0, 9'd0, 9'd256);
		add_row(CMD_TAS, 16'd37, 32'd3, 0, 1, STS_INUSE, 8'd37, 9'd0, 9'd256);
		add_row(CMD_SET, 16'd200, 32'd0, 0, 1, STS_OK, 8'd200, 9'd1, 9'd200);
		add_row(CMD_ADD, 16'd0, 32'd9, 0, 1, STS_OK, 8'd200, 9'd0, 9'd256);
		add_row(CMD_SET, 16'd3, 32'd0, 0, 1, STS_OK, 8'd3, 9'd1, 9'd3);
		add_row(CMD_ADD, 16'd0, 32'hA5A5_A5A5, 0, 1, STS_OK, 8'd3, 9'd0, 9'd256);
		add_row(CMD_SET, 16'd3, 32'd0, 0, 1, STS_OK, 8'd3, 9'd1, 9'd3);
		add_row(CMD_SET, 16'd3, 32'd0, 0, 1, STS_OK, 8'd3, 9'd1, 9'd3);
		add_row(CMD_TAS, 16'd3, 32'd1, 0, 1, STS_OK, 8'd3, 9'd0, 9'd256);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].fill_first) begin
				// Slot 0 is the only one in use here; take the other 255.
				for (int k = 1; k < CAP; k++) begin
					r = '{cmd: CMD_ADD, slot_index: 16'($urandom), slot_value: any_nonzero()};
					send_cmd(r, 1'b0, none);
				end
			end
			send_cmd(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);
		end

		// Random phases alternate between draining and filling the table.
		sent = 0;
		draining = 1'b1;
		while (sent < RANDOM_CMDS) begin
			phase_len = draining ? $urandom_range(100, 200) : $urandom_range(200, 350);
			for (int k = 0; k < phase_len && sent < RANDOM_CMDS; k++) begin
				if (k % 64 == 0) begin
					quiet_run = ($urandom_range(0, 3) == 0);
				end
				send_cmd(rand_cmd(draining), 1'b0, none);
				sent++;
			end
			draining = !draining;
		end
		start = 1'b0;
		drv_typed = 1'b0;

		// Drain outstanding results, then allow a few quiet cycles.
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin : watchdog
		#6_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule
